/* rtl/core/mrpt_pkg.sv */
// constants, types and the base table for the miller-rabin prime test core
// no dependencies; imported by miller_rabin_prime_test_u64_top
`default_nettype none

package mrpt_pkg;

    localparam int NUMBER_WIDTH = 64;
    localparam int NUM_BASES    = 7;
    localparam int BASE_W       = 5;
    localparam int IDX_W        = $clog2(NUM_BASES);
    localparam int SEXP_W       = $clog2(NUMBER_WIDTH);

    typedef logic [NUMBER_WIDTH-1:0] t_num;
    typedef logic [BASE_W-1:0]       t_base;
    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [SEXP_W-1:0]       t_sexp;

    // witness bases in test order
    function automatic t_base base_at(input t_idx idx);
        t_base b;
        unique case (idx)
            3'd0:    b = 5'd2;
            3'd1:    b = 5'd7;
            3'd2:    b = 5'd3;
            3'd3:    b = 5'd5;
            3'd4:    b = 5'd11;
            3'd5:    b = 5'd13;
            3'd6:    b = 5'd17;
            default: b = 5'd2;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/miller_rabin_prime_test_u64_top.sv */
// miller-rabin strong probable-prime test, bases 2 3 5 7 11 13 17, one number per command
// depends on mrpt_pkg
//
//   channel   dir  signals                    width  word
//   command   in   start, i_number (busy out) 64     candidate n
//   result    out  o_done, o_is_prime         1      pass of all seven bases
//
// n below 2 or even is settled in the decide state; other numbers go through the base tests.
// the run time is set by the single shift-add modular multiplier: one bit of the
// multiplier operand per cycle, about 2 * (64 - s) + s products per base, seven bases.
// busy is high from the cycle after start and drops in the cycle of o_done.
// reset is synchronous active low and clears the sequencer and the strobe.
// o_done is high for exactly one cycle; the receiver cannot stall.
`default_nettype none

module miller_rabin_prime_test_u64_top
    import mrpt_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    input  wire logic [NUMBER_WIDTH-1:0] i_number,
    output logic                         busy,
    output logic                         o_done,
    output logic                         o_is_prime
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SPLIT,
        ST_BASE,
        ST_REDUCE,
        ST_EXP_BIT,
        ST_EXP_SQR,
        ST_CHK_ONE,
        ST_LOOP,
        ST_MUL
    } t_state;

    typedef enum logic {
        DST_ACC,
        DST_B
    } t_dst;

    t_state r_state;
    t_state r_ret;
    t_dst   r_dst;
    t_num   r_n;
    t_num   r_nm1;
    t_num   r_d;
    t_sexp  r_s;
    t_sexp  r_cnt;
    t_idx   r_idx;
    t_num   r_b;
    t_num   r_acc;
    t_num   r_e;
    t_num   r_mx;
    t_num   r_my;
    t_num   r_macc;
    logic   r_done;
    logic   r_prime;

    // shared modular step: accumulate and double, each with one conditional subtract of n
    logic [NUMBER_WIDTH:0] m_sum;
    logic [NUMBER_WIDTH:0] m_sum_sub;
    logic [NUMBER_WIDTH:0] m_dbl;
    logic [NUMBER_WIDTH:0] m_dbl_sub;
    t_num                  n_macc;
    t_num                  n_mx;

    always_comb begin
        m_sum     = {1'b0, r_macc} + {1'b0, r_mx};
        m_sum_sub = m_sum - {1'b0, r_n};
        m_dbl     = {r_mx, 1'b0};
        m_dbl_sub = m_dbl - {1'b0, r_n};
        n_macc    = m_sum_sub[NUMBER_WIDTH] ? m_sum[NUMBER_WIDTH-1:0]
                                            : m_sum_sub[NUMBER_WIDTH-1:0];
        n_mx      = m_dbl_sub[NUMBER_WIDTH] ? m_dbl[NUMBER_WIDTH-1:0]
                                            : m_dbl_sub[NUMBER_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_n     <= i_number[NUMBER_WIDTH-1:0];
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    priority if (r_n < t_num'(2)) begin
                        r_prime <= 1'b0;
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else if (!r_n[0]) begin
                        r_prime <= (r_n == t_num'(2));
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_nm1   <= r_n - t_num'(1);
                        r_d     <= r_n - t_num'(1);
                        r_s     <= '0;
                        r_idx   <= '0;
                        r_state <= ST_SPLIT;
                    end
                end
                // strip trailing zeros of n-1 one bit a cycle
                ST_SPLIT: begin
                    if (!r_d[0]) begin
                        r_d <= r_d >> 1;
                        r_s <= r_s + t_sexp'(1);
                    end else begin
                        r_state <= ST_BASE;
                    end
                end
                ST_BASE: begin
                    if (r_n == t_num'(base_at(r_idx))) begin
                        if (r_idx == t_idx'(NUM_BASES - 1)) begin
                            r_prime <= 1'b1;
                            r_done  <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx + t_idx'(1);
                        end
                    end else begin
                        r_b     <= t_num'(base_at(r_idx));
                        r_state <= ST_REDUCE;
                    end
                end
                // base mod n by repeated subtraction, only a few steps for tiny n
                ST_REDUCE: begin
                    if (r_b >= r_n) begin
                        r_b <= r_b - r_n;
                    end else begin
                        r_acc   <= t_num'(1);
                        r_e     <= r_d;
                        r_state <= ST_EXP_BIT;
                    end
                end
                ST_EXP_BIT: begin
                    priority if (r_e == '0) begin
                        r_state <= ST_CHK_ONE;
                    end else if (r_e[0]) begin
                        r_mx    <= r_acc;
                        r_my    <= r_b;
                        r_macc  <= '0;
                        r_dst   <= DST_ACC;
                        r_ret   <= ST_EXP_SQR;
                        r_state <= ST_MUL;
                    end else begin
                        r_state <= ST_EXP_SQR;
                    end
                end
                // last squaring of the base is skipped, it no longer feeds the result
                ST_EXP_SQR: begin
                    r_e <= r_e >> 1;
                    if ((r_e >> 1) != '0) begin
                        r_mx    <= r_b;
                        r_my    <= r_b;
                        r_macc  <= '0;
                        r_dst   <= DST_B;
                        r_ret   <= ST_EXP_BIT;
                        r_state <= ST_MUL;
                    end else begin
                        r_state <= ST_EXP_BIT;
                    end
                end
                ST_CHK_ONE: begin
                    if (r_acc == t_num'(1)) begin
                        if (r_idx == t_idx'(NUM_BASES - 1)) begin
                            r_prime <= 1'b1;
                            r_done  <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx + t_idx'(1);
                            r_state <= ST_BASE;
                        end
                    end else begin
                        r_cnt   <= r_s;
                        r_state <= ST_LOOP;
                    end
                end
                ST_LOOP: begin
                    priority if (r_cnt == '0) begin
                        r_prime <= 1'b0;
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else if (r_acc == r_nm1) begin
                        if (r_idx == t_idx'(NUM_BASES - 1)) begin
                            r_prime <= 1'b1;
                            r_done  <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx + t_idx'(1);
                            r_state <= ST_BASE;
                        end
                    end else begin
                        r_cnt   <= r_cnt - t_sexp'(1);
                        r_mx    <= r_acc;
                        r_my    <= r_acc;
                        r_macc  <= '0;
                        r_dst   <= DST_ACC;
                        r_ret   <= ST_LOOP;
                        r_state <= ST_MUL;
                    end
                end
                // one multiplier bit per cycle, ends once the remaining bits are zero
                ST_MUL: begin
                    if (r_my == '0) begin
                        unique case (r_dst)
                            DST_ACC: r_acc <= r_macc;
                            DST_B:   r_b   <= r_macc;
                            default: r_acc <= r_macc;
                        endcase
                        r_state <= r_ret;
                    end else begin
                        if (r_my[0]) begin
                            r_macc <= n_macc;
                        end
                        r_mx <= n_mx;
                        r_my <= r_my >> 1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy       = (r_state != ST_IDLE);
    assign o_done     = r_done;
    assign o_is_prime = r_prime;

endmodule

`default_nettype wire

/* rtl/core/mrpt_checker.sv */
// port-level checks on the command and result handshake of the prime test core
// depends on miller_rabin_prime_test_u64_top ports only; bound to the top level below
`default_nettype none

module mrpt_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_done,
    input wire logic o_is_prime
);

    // an accepted word always makes the core busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // the result strobe is a single cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // the result shows in the cycle busy drops
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && $past(busy)))
        else $error("result strobe outside end of work");

    // busy never drops without a result
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_done)
        else $error("busy dropped without a result");

    // the result bit is defined whenever it is strobed
    a_result_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$isunknown(o_is_prime))
        else $error("unknown result on strobe");

endmodule

bind miller_rabin_prime_test_u64_top mrpt_checker u_mrpt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_done     (o_done),
    .o_is_prime (o_is_prime)
);

`default_nettype wire
